// ----- sv/rhpt_pkg.sv -----
// ----------------------------------------------------------------------------
// rhpt_pkg
// shared widths and constants of the ring history peak tracker
// ----------------------------------------------------------------------------
package rhpt_pkg;

  localparam int unsigned VAL_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PEAK_W   = 15;
  localparam int unsigned HOURS_W  = 29;
  localparam int unsigned HELD_W   = 8;

  // age * 256 / 3600 == (age * 16) / 225 == (age * ceil(2^44 / 225)) >> 40
  // exact for every 32-bit age; reciprocal kept as RECIP_HI * 2^32 + RECIP_LO
  localparam int unsigned            RECIP_HI_W  = 5;
  localparam logic [TIME_W-1:0]      RECIP_LO    = 32'd878082203;
  localparam logic [RECIP_HI_W-1:0]  RECIP_HI    = 5'd18;
  localparam int unsigned            RECIP_SHIFT = 40;

endpackage

// ----- sv/ring_history_peak_tracker_top.sv -----
// ----------------------------------------------------------------------------
// ring_history_peak_tracker_top
// ring of timestamped samples with a window peak and peak age
// ----------------------------------------------------------------------------
// Usage: each input word (in_sample_value, in_sample_time) is written into a
// ring of DEPTH entries, overwriting the oldest one once the ring is full.
// The block then reads back every retained entry, oldest first, through the
// single read port of the sample and time memories, one entry a cycle, to
// find the first strictly greatest positive sample and the newest timestamp.
// The peak age is then converted to hours in Q.8 by a reciprocal multiply:
// two partial products in state S_MUL, the add and shift in the cycle that
// loads the output register. One result word follows each input word.
// One word is processed at a time. in_ready is high while no word is being
// processed; a new word may be taken while the previous result still waits
// on the output register. When the receiver stalls, the finished result of
// the next word waits inside the block until the output register is free.
// Reset clears the fill count, oldest pointer, full flag and handshake
// state; memory contents need no clearing since only written entries are
// read.
// ----------------------------------------------------------------------------
module ring_history_peak_tracker_top #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rhpt_pkg::VAL_W-1:0]   in_sample_value,
  input  logic        [rhpt_pkg::TIME_W-1:0]  in_sample_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rhpt_pkg::VAL_W-1:0]   out_current_value,
  output logic                                out_peak_found,
  output logic        [rhpt_pkg::PEAK_W-1:0]  out_peak_value,
  output logic        [rhpt_pkg::TIME_W-1:0]  out_peak_age_seconds,
  output logic        [rhpt_pkg::HOURS_W-1:0] out_peak_age_hours_q8,
  output logic        [rhpt_pkg::HELD_W-1:0]  out_entries_held,
  output logic                                out_ring_full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = rhpt_pkg::VAL_W;
  localparam int unsigned TW = rhpt_pkg::TIME_W;
  localparam int unsigned QW = rhpt_pkg::HOURS_W;
  localparam int unsigned XW = rhpt_pkg::RECIP_HI_W;
  localparam int unsigned PW = TW + TW;
  localparam int unsigned HW = TW + XW;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MUL, S_OUT} state_t;

  // memories
  logic signed [VW-1:0] vmem [DEPTH];
  logic        [TW-1:0] tmem [DEPTH];
  logic signed [VW-1:0] vmem_q;
  logic        [TW-1:0] tmem_q;
  logic                 mem_we;
  logic                 mem_re;
  logic        [AW-1:0] wr_addr;

  // state
  state_t               state_r, state_nxt;
  logic        [CW-1:0] fill_r, fill_nxt;
  logic        [AW-1:0] oldest_r, oldest_nxt;
  logic                 full_r, full_nxt;
  logic signed [VW-1:0] cur_r, cur_nxt;
  logic        [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic        [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic signed [VW-1:0] peak_r, peak_nxt;
  logic        [TW-1:0] peak_time_r, peak_time_nxt;
  logic                 found_r, found_nxt;
  logic        [TW-1:0] newest_r, newest_nxt;
  logic        [TW-1:0] age_r, age_nxt;
  logic        [PW-1:0] prod_lo_r, prod_lo_nxt;
  logic        [HW-1:0] prod_hi_r, prod_hi_nxt;

  // output register
  logic                 ov_r, ov_nxt;
  logic signed [VW-1:0] o_cur_r, o_cur_nxt;
  logic                 o_found_r, o_found_nxt;
  logic [rhpt_pkg::PEAK_W-1:0] o_peak_r, o_peak_nxt;
  logic        [TW-1:0] o_age_r, o_age_nxt;
  logic        [QW-1:0] o_hours_r, o_hours_nxt;
  logic [rhpt_pkg::HELD_W-1:0] o_held_r, o_held_nxt;
  logic                 o_full_r, o_full_nxt;

  logic        [HW-1:0] prod_sum;
  logic        [CW-1:0] fill_inc;
  logic        [AW-1:0] slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem[wr_addr] <= in_sample_value;
      tmem[wr_addr] <= in_sample_time;
    end
    if (mem_re) begin
      vmem_q <= vmem[rd_addr_r];
      tmem_q <= tmem[rd_addr_r];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    oldest_nxt    = oldest_r;
    full_nxt      = full_r;
    cur_nxt       = cur_r;
    rd_addr_nxt   = rd_addr_r;
    rd_cnt_nxt    = rd_cnt_r;
    rd_vld_nxt    = 1'b0;
    peak_nxt      = peak_r;
    peak_time_nxt = peak_time_r;
    found_nxt     = found_r;
    newest_nxt    = newest_r;
    age_nxt       = age_r;
    prod_lo_nxt   = prod_lo_r;
    prod_hi_nxt   = prod_hi_r;
    ov_nxt        = ov_r & ~out_ready;
    o_cur_nxt     = o_cur_r;
    o_found_nxt   = o_found_r;
    o_peak_nxt    = o_peak_r;
    o_age_nxt     = o_age_r;
    o_hours_nxt   = o_hours_r;
    o_held_nxt    = o_held_r;
    o_full_nxt    = o_full_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    in_ready      = (state_r == S_IDLE);
    fill_inc      = fill_r + CW'(1);
    slot          = full_r ? oldest_r : AW'(fill_r);
    wr_addr       = slot;
    prod_sum      = prod_hi_r + {{XW{1'b0}}, prod_lo_r[PW-1:TW]};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mem_we  = 1'b1;
          cur_nxt = in_sample_value;
          if (full_r) begin
            oldest_nxt = (slot == AW'(DEPTH - 1)) ? '0 : slot + AW'(1);
          end else begin
            fill_nxt = fill_inc;
            if (fill_inc == CW'(DEPTH)) begin
              full_nxt = 1'b1;
            end
          end
          rd_addr_nxt = oldest_nxt;
          rd_cnt_nxt  = '0;
          peak_nxt    = '0;
          found_nxt   = 1'b0;
          newest_nxt  = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_cnt_r < fill_r) begin
          mem_re      = 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_cnt_nxt  = rd_cnt_r + CW'(1);
          rd_addr_nxt = (rd_addr_r == AW'(DEPTH - 1)) ? '0 : rd_addr_r + AW'(1);
        end
        if (rd_vld_r) begin
          if (vmem_q > peak_r) begin
            peak_nxt      = vmem_q;
            peak_time_nxt = tmem_q;
            found_nxt     = 1'b1;
          end
          if (tmem_q > newest_r) begin
            newest_nxt = tmem_q;
          end
        end else if (rd_cnt_r == fill_r) begin
          if (found_r && (newest_r >= peak_time_r)) begin
            age_nxt = newest_r - peak_time_r;
          end else begin
            age_nxt = '0;
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_lo_nxt = {{TW{1'b0}}, age_r} * {{TW{1'b0}}, rhpt_pkg::RECIP_LO};
        prod_hi_nxt = {{XW{1'b0}}, age_r} * {{TW{1'b0}}, rhpt_pkg::RECIP_HI};
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt      = 1'b1;
          o_cur_nxt   = cur_r;
          o_found_nxt = found_r;
          o_peak_nxt  = found_r ? peak_r[rhpt_pkg::PEAK_W-1:0] : '0;
          o_age_nxt   = age_r;
          o_hours_nxt = prod_sum[rhpt_pkg::RECIP_SHIFT-TW +: QW];
          o_held_nxt  = rhpt_pkg::HELD_W'(fill_r);
          o_full_nxt  = full_r;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      oldest_r <= '0;
      full_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
      full_r   <= full_nxt;
      rd_vld_r <= rd_vld_nxt;
      ov_r     <= ov_nxt;
    end
    cur_r       <= cur_nxt;
    rd_addr_r   <= rd_addr_nxt;
    rd_cnt_r    <= rd_cnt_nxt;
    peak_r      <= peak_nxt;
    peak_time_r <= peak_time_nxt;
    found_r     <= found_nxt;
    newest_r    <= newest_nxt;
    age_r       <= age_nxt;
    prod_lo_r   <= prod_lo_nxt;
    prod_hi_r   <= prod_hi_nxt;
    o_cur_r     <= o_cur_nxt;
    o_found_r   <= o_found_nxt;
    o_peak_r    <= o_peak_nxt;
    o_age_r     <= o_age_nxt;
    o_hours_r   <= o_hours_nxt;
    o_held_r    <= o_held_nxt;
    o_full_r    <= o_full_nxt;
  end

  assign out_valid             = ov_r;
  assign out_current_value     = o_cur_r;
  assign out_peak_found        = o_found_r;
  assign out_peak_value        = o_peak_r;
  assign out_peak_age_seconds  = o_age_r;
  assign out_peak_age_hours_q8 = o_hours_r;
  assign out_entries_held      = o_held_r;
  assign out_ring_full         = o_full_r;

endmodule

// ----- test/peak_tracker_checker.sv -----
// ----------------------------------------------------------------------------
// peak_tracker_checker
// Watches both channels of the ring history peak tracker. It keeps its own
// copy of the sample ring and works out the window peak, the peak age and
// the fill state for each word taken in. Each result word is compared field
// by field with the oldest prediction. Counts of mismatches, of waiting
// predictions and of results seen go back to the testbench top.
// ----------------------------------------------------------------------------
module peak_tracker_checker #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [rhpt_pkg::VAL_W-1:0]   in_sample_value,
  input  logic        [rhpt_pkg::TIME_W-1:0]  in_sample_time,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [rhpt_pkg::VAL_W-1:0]   out_current_value,
  input  logic                                out_peak_found,
  input  logic        [rhpt_pkg::PEAK_W-1:0]  out_peak_value,
  input  logic        [rhpt_pkg::TIME_W-1:0]  out_peak_age_seconds,
  input  logic        [rhpt_pkg::HOURS_W-1:0] out_peak_age_hours_q8,
  input  logic        [rhpt_pkg::HELD_W-1:0]  out_entries_held,
  input  logic                                out_ring_full,
  output int                                  fail_count,
  output int                                  pending_count,
  output int                                  result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VAL_W   = rhpt_pkg::VAL_W;
  localparam int unsigned TIME_W  = rhpt_pkg::TIME_W;
  localparam int unsigned PEAK_W  = rhpt_pkg::PEAK_W;
  localparam int unsigned HOURS_W = rhpt_pkg::HOURS_W;
  localparam int unsigned HELD_W  = rhpt_pkg::HELD_W;

  typedef struct {
    logic signed [VAL_W-1:0] current_value;
    logic                    peak_found;
    logic [PEAK_W-1:0]       peak_value;
    logic [TIME_W-1:0]       age_seconds;
    logic [HOURS_W-1:0]      age_hours_q8;
    logic [HELD_W-1:0]       entries_held;
    logic                    ring_full;
  } peak_report_t;

  logic signed [VAL_W-1:0] ring_value [DEPTH];
  logic [TIME_W-1:0]       ring_time  [DEPTH];
  int unsigned             held_count;
  int unsigned             oldest_idx;
  bit                      ring_is_full;

  peak_report_t expected_reports [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    result_count  = 0;
    held_count    = 0;
    oldest_idx    = 0;
    ring_is_full  = 1'b0;
  end

  function automatic peak_report_t track_sample(input logic signed [VAL_W-1:0] value,
                                                input logic [TIME_W-1:0] stamp);
    peak_report_t            rep;
    int unsigned             slot;
    int unsigned             idx;
    logic signed [VAL_W-1:0] best;
    logic [TIME_W-1:0]       best_time;
    logic [TIME_W-1:0]       newest;
    logic [TIME_W-1:0]       age;
    logic [63:0]             wide_hours;
    bit                      found;
    if (ring_is_full) begin
      slot = oldest_idx;
      oldest_idx = (oldest_idx + 1) % DEPTH;
    end else begin
      slot = held_count;
      held_count++;
      if (held_count >= DEPTH) ring_is_full = 1'b1;
    end
    ring_value[slot] = value;
    ring_time[slot] = stamp;
    best = '0;
    best_time = '0;
    newest = '0;
    found = 1'b0;
    age = '0;
    wide_hours = '0;
    // oldest first, strict compare keeps the first of equal peaks
    for (int i = 0; i < held_count; i++) begin
      idx = (oldest_idx + i) % DEPTH;
      if (ring_value[idx] > best) begin
        best = ring_value[idx];
        best_time = ring_time[idx];
        found = 1'b1;
      end
      if (ring_time[idx] > newest) newest = ring_time[idx];
    end
    if (found) begin
      age = newest - best_time;
      wide_hours = ({32'd0, age} * 64'd256) / 64'd3600;
    end
    rep.current_value = value;
    rep.peak_found = found;
    rep.peak_value = best[PEAK_W-1:0];
    rep.age_seconds = age;
    rep.age_hours_q8 = wide_hours[HOURS_W-1:0];
    rep.entries_held = held_count[HELD_W-1:0];
    rep.ring_full = ring_is_full;
    return rep;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on word %0d: %s expected %0h got %0h", result_count, what,
                 want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    peak_report_t want;
    if (!rst_n) begin
      held_count = 0;
      oldest_idx = 0;
      ring_is_full = 1'b0;
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word %0d: current_value %0h", result_count,
                     out_current_value);
        end else begin
          want = expected_reports.pop_front();
          check_field("current_value", 64'(unsigned'(want.current_value)),
                      64'(unsigned'(out_current_value)));
          check_field("peak_found", 64'(want.peak_found), 64'(out_peak_found));
          check_field("peak_value", 64'(want.peak_value), 64'(out_peak_value));
          check_field("peak_age_seconds", 64'(want.age_seconds), 64'(out_peak_age_seconds));
          check_field("peak_age_hours_q8", 64'(want.age_hours_q8),
                      64'(out_peak_age_hours_q8));
          check_field("entries_held", 64'(want.entries_held), 64'(out_entries_held));
          check_field("ring_full", 64'(want.ring_full), 64'(out_ring_full));
        end
      end
      if (in_valid && in_ready)
        expected_reports.push_back(track_sample(in_sample_value, in_sample_time));
    end
    pending_count = expected_reports.size();
  end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the ring history peak tracker with a short directed run over the
// field extremes, ties and peak-free windows, then with bursts of random
// words: rising timestamps with ordinary growth values, stretches with no
// positive sample, tie-heavy stretches and fully random words. Both sides
// idle at random; the receiver holds off once for a long stretch and the
// sender once drains the block. The checker beside the block does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned     VAL_W           = rhpt_pkg::VAL_W;
  localparam int unsigned     TIME_W          = rhpt_pkg::TIME_W;
  localparam int unsigned     PEAK_W          = rhpt_pkg::PEAK_W;
  localparam int unsigned     HOURS_W         = rhpt_pkg::HOURS_W;
  localparam int unsigned     HELD_W          = rhpt_pkg::HELD_W;

  localparam int unsigned     DEPTH           = 128;
  localparam int unsigned     RANDOM_WORDS    = 1950;
  localparam int unsigned     PAUSE_AT        = 900;
  localparam int unsigned     HOLD_OFF_AT     = 500;
  localparam int unsigned     HOLD_OFF_CYCLES = 3000;
  localparam longint unsigned CYCLE_LIMIT     = 5000000;

  typedef enum int {
    BURST_RISING,
    BURST_NONPOS,
    BURST_TIES,
    BURST_WILD
  } burst_kind_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [VAL_W-1:0]     in_sample_value;
  logic        [TIME_W-1:0]    in_sample_time;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [VAL_W-1:0]     out_current_value;
  logic                        out_peak_found;
  logic        [PEAK_W-1:0]    out_peak_value;
  logic        [TIME_W-1:0]    out_peak_age_seconds;
  logic        [HOURS_W-1:0]   out_peak_age_hours_q8;
  logic        [HELD_W-1:0]    out_entries_held;
  logic                        out_ring_full;

  int              fail_count;
  int              pending_count;
  int              result_count;
  longint unsigned cycle_count;

  ring_history_peak_tracker_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sample_value      (in_sample_value),
    .in_sample_time       (in_sample_time),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_current_value    (out_current_value),
    .out_peak_found       (out_peak_found),
    .out_peak_value       (out_peak_value),
    .out_peak_age_seconds (out_peak_age_seconds),
    .out_peak_age_hours_q8(out_peak_age_hours_q8),
    .out_entries_held     (out_entries_held),
    .out_ring_full        (out_ring_full)
  );

  peak_tracker_checker #(
    .DEPTH(DEPTH)
  ) peak_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sample_value      (in_sample_value),
    .in_sample_time       (in_sample_time),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_current_value    (out_current_value),
    .out_peak_found       (out_peak_found),
    .out_peak_value       (out_peak_value),
    .out_peak_age_seconds (out_peak_age_seconds),
    .out_peak_age_hours_q8(out_peak_age_hours_q8),
    .out_entries_held     (out_entries_held),
    .out_ring_full        (out_ring_full),
    .fail_count           (fail_count),
    .pending_count        (pending_count),
    .result_count         (result_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 30);
    return $urandom_range(31, 150);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_word(input logic [VAL_W-1:0] value, input logic [TIME_W-1:0] stamp,
                            input int unsigned gap);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample_value = value;
    in_sample_time = stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned quiet_left;
    bit          quiet;
    bit          held_off;
    out_ready = 1'b0;
    stall_left = 0;
    quiet_left = 0;
    quiet = 1'b0;
    held_off = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (!held_off && result_count >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      if (quiet_left == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        quiet_left = $urandom_range(50, 400);
      end
      quiet_left--;
      if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0)
        stall_left = idle_length();
      if (stall_left != 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
      @(negedge clk);
    end
  end

  initial begin : word_source
    burst_kind_t       kind;
    logic [VAL_W-1:0]  value;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] clock_s;
    int unsigned       words_sent;
    int unsigned       burst_len;
    bit                quiet;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_value = '0;
    in_sample_time = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no positive sample yet
    offer_word(16'h0000, 32'd0, 0);
    offer_word(16'h8000, 32'd5, idle_length());
    offer_word(16'hffff, 32'd10, 0);
    // smallest peak, then largest peak at time zero
    offer_word(16'h0001, 32'd100, idle_length());
    offer_word(16'h7fff, 32'd0, 0);
    // equal peak later, first one keeps its age at the widest span
    offer_word(16'h7fff, 32'hffff_ffff, 0);
    offer_word(16'd100, 32'd3600, idle_length());
    offer_word(16'h5555, 32'haaaa_aaaa, 0);
    offer_word(16'haaaa, 32'h5555_5555, 0);
    offer_word(16'h7ffe, 32'd7200, idle_length());
    offer_word(16'h0000, 32'hffff_fffe, 0);
    offer_word(16'h8001, 32'd1, 0);

    words_sent = 0;
    clock_s = 32'd1000;
    while (words_sent < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: kind = BURST_RISING;
        4, 5:       kind = BURST_NONPOS;
        6, 7:       kind = BURST_TIES;
        default:    kind = BURST_WILD;
      endcase
      burst_len = $urandom_range(20, 200);
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst_len && words_sent < RANDOM_WORDS; k++) begin
        value = VAL_W'($urandom);
        clock_s = clock_s + TIME_W'($urandom_range(0, 900));
        stamp = clock_s;
        case (kind)
          BURST_NONPOS: if ($signed(value) > 0) value = -value;
          BURST_TIES: begin
            case ($urandom_range(0, 4))
              0:       value = 16'h0000;
              1:       value = 16'h0001;
              2:       value = 16'h7fff;
              3:       value = 16'h8000;
              default: value = 16'h0002;
            endcase
          end
          BURST_WILD: stamp = TIME_W'($urandom);
          default: value = VAL_W'($urandom_range(0, 400)) - VAL_W'(200);
        endcase
        if (words_sent == PAUSE_AT) begin
          // drain the block before going on
          in_valid = 1'b0;
          while (pending_count != 0) @(negedge clk);
        end
        offer_word(value, stamp, quiet ? 0 : idle_length());
        words_sent++;
      end
    end
    in_valid = 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (DEPTH + 60) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
